// ----- design/hotp_pkg.sv -----
// Package with SHA-1 constants, shared types and helper functions for the HOTP core.
`timescale 1ns / 1ps
package hotp_pkg;

  localparam int unsigned KeyBytesDefault   = 32;
  localparam int unsigned CodeDigitsDefault = 6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KLEN = 3'd4;

  // Block selection for the shared compression unit.
  typedef enum logic [1:0] {
    BLK_IKEY = 2'd0,
    BLK_MSG  = 2'd1,
    BLK_OKEY = 2'd2,
    BLK_IH   = 2'd3
  } blk_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_TRUNC,
    ST_MOD,
    ST_OUT
  } state_e;

  // Control from sequencer to compression unit.
  typedef struct packed {
    logic load;   // load block words and chaining init
    logic round;  // run one round
    logic fold;   // add working vars into chaining value
    logic init;   // start chaining value from IV
  } sha_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [32:0] pow10(input int unsigned d);
    logic [32:0] r;
    r = 33'd1;
    for (int unsigned i = 0; i < d; i++) begin
      r = r * 33'd10;
    end
    pow10 = r;
  endfunction

endpackage

// ----- design/hotp_sha1.sv -----
// Iterative SHA-1 compression unit: one round per cycle while round is set, sliding message schedule.
`timescale 1ns / 1ps
module hotp_sha1 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hotp_pkg::sha_ctrl_t     ctrl_i,
  input  logic [511:0]            block_i,
  output logic [159:0]            hash_o
);

  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [6:0]  rnd_q;
  logic [31:0] f, k, t, wnext;

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = hotp_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = hotp_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = hotp_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = hotp_pkg::K3;
    end
    t = hotp_pkg::rotl(a_q, 5) + f + e_q + k + w_q[0];
    wnext = hotp_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
    for (int i = 0; i < 15; i++) begin
      w_d[i] = w_q[i + 1];
    end
    w_d[15] = wnext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (ctrl_i.load) begin
      rnd_q <= '0;
    end else if (ctrl_i.round) begin
      rnd_q <= rnd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511 - 32*i -: 32];
      end
      if (ctrl_i.init) begin
        h_q[0] <= hotp_pkg::H0; h_q[1] <= hotp_pkg::H1; h_q[2] <= hotp_pkg::H2;
        h_q[3] <= hotp_pkg::H3; h_q[4] <= hotp_pkg::H4;
        a_q <= hotp_pkg::H0; b_q <= hotp_pkg::H1; c_q <= hotp_pkg::H2;
        d_q <= hotp_pkg::H3; e_q <= hotp_pkg::H4;
      end else begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
      end
    end else if (ctrl_i.round) begin
      w_q <= w_d;
      a_q <= t;
      b_q <= a_q;
      c_q <= hotp_pkg::rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
    end else if (ctrl_i.fold) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign hash_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

endmodule

// ----- design/hotp_hmac_sha1_code_core.sv -----
// Top level of the HOTP core: key registers, block builder, sequencer, truncation and modulo.
`timescale 1ns / 1ps
// One code per moving factor. An accepted item runs four SHA-1 compressions on one
// shared round unit, each a load step, 80 rounds and a fold step, then a truncation step
// and three modulo steps (reciprocal multiply, multiply-subtract, final correction),
// before out_valid_o rises. in_stall_o is high from the transfer until the result is
// taken, and the next factor is taken only once the core is back in the idle state,
// so a new factor is not accepted before the last result is taken. Key registers reset
// to zero with length 20.
module hotp_hmac_sha1_code_core #(
  parameter int unsigned KEY_BYTES   = hotp_pkg::KeyBytesDefault,
  parameter int unsigned CODE_DIGITS = hotp_pkg::CodeDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] moving_factor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] otp_code_o
);

  localparam int unsigned LenCap = (KEY_BYTES < 32) ? KEY_BYTES : 32;
  localparam logic [32:0] Modulus = hotp_pkg::pow10(CODE_DIGITS);
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(Modulus));

  logic [63:0] key_q [4];
  logic [5:0]  klen_q;
  logic [63:0] mf_q;
  hotp_pkg::state_e st_q, st_d;
  hotp_pkg::blk_sel_e sel_q, sel_d;
  logic [6:0]  cnt_q, cnt_d;
  hotp_pkg::sha_ctrl_t ctrl;
  logic [511:0] block;
  logic [159:0] hash;
  logic [159:0] ih_q;
  logic [32:0] rem_q;
  logic [30:0] bin_q;
  logic [62:0] prod_q;
  logic        ld_trunc, ld_mod, take_in, take_ih;
  logic [5:0]  len_eff;
  logic [255:0] key_flat;
  logic [511:0] key_blk;
  logic [7:0]  pad;
  logic [3:0]  off;
  logic [31:0] sel4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      klen_q <= 6'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hotp_pkg::REG_KEY0: key_q[0] <= cfg_data_i;
        hotp_pkg::REG_KEY1: key_q[1] <= cfg_data_i;
        hotp_pkg::REG_KEY2: key_q[2] <= cfg_data_i;
        hotp_pkg::REG_KEY3: key_q[3] <= cfg_data_i;
        hotp_pkg::REG_KLEN: klen_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = (klen_q > 6'(LenCap)) ? 6'(LenCap) : klen_q;
    key_flat = {key_q[0], key_q[1], key_q[2], key_q[3]};
    pad = (sel_q == hotp_pkg::BLK_OKEY) ? hotp_pkg::OPAD : hotp_pkg::IPAD;
    for (int i = 0; i < 64; i++) begin
      if (i < 32 && 6'(i) < len_eff) begin
        key_blk[511 - 8*i -: 8] = key_flat[255 - 8*i -: 8] ^ pad;
      end else begin
        key_blk[511 - 8*i -: 8] = pad;
      end
    end
    case (sel_q)
      hotp_pkg::BLK_MSG: block = {mf_q, 32'h80000000, 384'd0, 32'd576};
      hotp_pkg::BLK_IH:  block = {ih_q, 32'h80000000, 288'd0, 32'd672};
      default:           block = key_blk;
    endcase
  end

  hotp_sha1 u_sha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .block_i(block),
    .hash_o (hash)
  );

  always_comb begin
    st_d = st_q;
    sel_d = sel_q;
    cnt_d = cnt_q;
    ctrl = '0;
    take_in = 1'b0;
    take_ih = 1'b0;
    ld_trunc = 1'b0;
    ld_mod = 1'b0;
    case (st_q)
      hotp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          take_in = 1'b1;
          sel_d = hotp_pkg::BLK_IKEY;
          st_d = hotp_pkg::ST_LOAD;
        end
      end
      hotp_pkg::ST_LOAD: begin
        ctrl.load = 1'b1;
        ctrl.init = (sel_q == hotp_pkg::BLK_IKEY) || (sel_q == hotp_pkg::BLK_OKEY);
        take_ih = (sel_q == hotp_pkg::BLK_OKEY);
        cnt_d = '0;
        st_d = hotp_pkg::ST_ROUND;
      end
      hotp_pkg::ST_ROUND: begin
        ctrl.round = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd79) begin
          st_d = hotp_pkg::ST_FOLD;
        end
      end
      hotp_pkg::ST_FOLD: begin
        ctrl.fold = 1'b1;
        case (sel_q)
          hotp_pkg::BLK_IKEY: begin
            sel_d = hotp_pkg::BLK_MSG;
            st_d = hotp_pkg::ST_LOAD;
          end
          hotp_pkg::BLK_MSG: begin
            sel_d = hotp_pkg::BLK_OKEY;
            st_d = hotp_pkg::ST_LOAD;
          end
          hotp_pkg::BLK_OKEY: begin
            sel_d = hotp_pkg::BLK_IH;
            st_d = hotp_pkg::ST_LOAD;
          end
          default: st_d = hotp_pkg::ST_TRUNC;
        endcase
      end
      hotp_pkg::ST_TRUNC: begin
        ld_trunc = 1'b1;
        cnt_d = '0;
        st_d = hotp_pkg::ST_MOD;
      end
      hotp_pkg::ST_MOD: begin
        ld_mod = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd2) begin
          st_d = hotp_pkg::ST_OUT;
        end
      end
      hotp_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          st_d = hotp_pkg::ST_IDLE;
        end
      end
      default: st_d = hotp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hotp_pkg::ST_IDLE;
      sel_q <= hotp_pkg::BLK_IKEY;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      sel_q <= sel_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    off = hash[3:0];
    sel4 = hash[159 - 8*off -: 32];
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      mf_q <= moving_factor_i;
    end
    if (take_ih) begin
      ih_q <= hash;
    end
    if (ld_trunc) begin
      bin_q <= sel4[30:0];
      rem_q <= '0;
    end else if (ld_mod) begin
      case (cnt_q)
        7'd0: prod_q <= {32'd0, bin_q} * {31'd0, Recip};
        7'd1: rem_q <= {2'b00, 31'(bin_q - prod_q[62:32] * Modulus[30:0])};
        default: begin
          if (rem_q >= Modulus) begin
            rem_q <= rem_q - Modulus;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (st_q != hotp_pkg::ST_IDLE);
  assign out_valid_o = (st_q == hotp_pkg::ST_OUT);
  assign otp_code_o  = rem_q[19:0];

  ap_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("result shown while accepting");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(otp_code_o))
    else $error("result changed under stall");
  ap_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rem_q < Modulus) else $error("remainder not reduced");
  ap_round_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == hotp_pkg::ST_ROUND |-> cnt_q < 7'd80) else $error("round count overrun");

endmodule
